// ===== rtl/cstc_pkg.sv =====
// Shared types, constants and codes for the capacitated subset tour cost block.
`default_nettype none
package cstc_pkg;

   // defaults for top-level parameters
   localparam int MAX_LOCATIONS_DEF = 12;
   localparam int DIST_WIDTH_DEF    = 16;

   // fixed field widths
   localparam int OP_W     = 2;
   localparam int ROW_W    = 4;
   localparam int LOAD_W   = 16;
   localparam int MASK_W   = 11;
   localparam int DEMAND_W = 16;
   localparam int COST_W   = 20;
   localparam int NUMLOC_W = 4;
   localparam int CAP_W    = 16;
   localparam int REQ_W    = 40;
   localparam int RSP_W    = 24;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [COST_W-1:0]   COST_MAX     = {COST_W{1'b1}};
   localparam logic [NUMLOC_W-1:0] NUMLOC_RESET = 4'd12;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_LOCATIONS    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_VEHICLE_CAPACITY = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE_DIST   = 2'd0,
      OP_WRITE_DEMAND = 2'd1,
      OP_RUN          = 2'd2,
      OP_QUERY        = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QWAIT,
      ST_CHK,
      ST_DEM,
      ST_FEAS,
      ST_JSEL,
      ST_ROOT,
      ST_RD,
      ST_ACC,
      ST_WPATH,
      ST_FIN,
      ST_WTOUR,
      ST_NEXT
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/cstc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module cstc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// ===== rtl/capacitated_subset_tour_cost_top.sv =====
// Capacitated subset tour cost: distance/demand loads, Held-Karp table run, subset queries.
// Usage:
//   req carries one command per transfer: write distance, write demand, run table
//   or query subset. Only a query returns a transfer on rsp.
//   csr sets the location count (index 0) and vehicle capacity (index 1); write it
//   only while the block is idle. New settings and loads take effect at the next run.
// Timing:
//   Loads are written at their transfer. A query's result passes the registered
//   tour RAM read, then the output register, before it is valid on rsp.
//   A run walks every customer subset through one shared add/compare unit: an
//   empty or out-of-use subset is only checked and written infeasible, an
//   over-capacity one also has its demands summed, and a feasible one also gets
//   its path costs and the closing leg to the depot. req_tready stays low for
//   the whole run.
// Reset:
//   Location count 12, capacity 0; queries report cost 0 and infeasible until the
//   first run completes. No memory clearing pass.
// Stall:
//   A pending result sits in the output register and holds off every command
//   until it is taken.
`default_nettype none
module capacitated_subset_tour_cost_top #(
   parameter int MAX_LOCATIONS = cstc_pkg::MAX_LOCATIONS_DEF,
   parameter int DIST_WIDTH    = cstc_pkg::DIST_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // operation[1:0], row_index[5:2], col_index[9:6], load_value[25:10],
   // subset_mask[36:26], zero fill
   input  wire logic [cstc_pkg::REQ_W-1:0]        req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tour_cost[19:0], feasible[20], zero fill
   output logic      [cstc_pkg::RSP_W-1:0]        rsp_tdata,
   input  wire logic                              csr_we,
   input  wire logic [cstc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [cstc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int NCUST    = MAX_LOCATIONS - 1;
   localparam int NSUBSETS = 1 << NCUST;
   localparam int LIW      = $clog2(MAX_LOCATIONS);
   localparam int JIW      = $clog2(NCUST);
   localparam int DAW      = $clog2(MAX_LOCATIONS * MAX_LOCATIONS);
   localparam int PAW      = $clog2(NSUBSETS * NCUST);
   localparam int COST_W   = cstc_pkg::COST_W;
   localparam int TOT_W    = cstc_pkg::DEMAND_W + $clog2(NCUST + 1);
   localparam int SUM_W    = ((DIST_WIDTH > COST_W) ? DIST_WIDTH : COST_W) + 1;

   // request fields
   cstc_pkg::op_type                 req_op;
   logic [cstc_pkg::ROW_W-1:0]       req_row;
   logic [cstc_pkg::ROW_W-1:0]       req_col;
   logic [cstc_pkg::LOAD_W-1:0]      req_load;
   logic [cstc_pkg::MASK_W-1:0]      req_mask;

   assign req_op   = cstc_pkg::op_type'(req_tdata[1:0]);
   assign req_row  = req_tdata[5:2];
   assign req_col  = req_tdata[9:6];
   assign req_load = req_tdata[25:10];
   assign req_mask = req_tdata[36:26];

   // registers
   cstc_pkg::state_type               state_ff, state_in;
   logic [cstc_pkg::NUMLOC_W-1:0]     numloc_ff;
   logic [cstc_pkg::CAP_W-1:0]        cap_ff;
   logic [cstc_pkg::DEMAND_W-1:0]     demand_ff [MAX_LOCATIONS];
   logic [NCUST-1:0]                  m_ff, m_in;
   logic [JIW-1:0]                    j_ff, j_in;
   logic [JIW-1:0]                    v_ff, v_in;
   logic [TOT_W-1:0]                  total_ff, total_in;
   logic [COST_W-1:0]                 best_ff, best_in;
   logic                              have_ff, have_in;
   logic [NCUST-1:0]                  set_ff, set_in;
   logic [LIW-1:0]                    tgt_ff, tgt_in;
   logic                              fin_ff, fin_in;
   logic                              table_valid_ff, table_valid_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [COST_W-1:0]                 rsp_cost_ff, rsp_cost_in;
   logic                              rsp_feas_ff, rsp_feas_in;

   // memory ports
   logic                    dist_we;
   logic [DAW-1:0]          dist_waddr, dist_raddr;
   logic [DIST_WIDTH-1:0]   dist_rd;
   logic                    path_we;
   logic [PAW-1:0]          path_waddr, path_raddr;
   logic [COST_W-1:0]       path_wdata, path_rd;
   logic                    tour_we;
   logic [NCUST-1:0]        tour_waddr, tour_raddr;
   logic [COST_W:0]         tour_wdata, tour_rd;

   cstc_ram #(.WIDTH(DIST_WIDTH), .DEPTH(MAX_LOCATIONS * MAX_LOCATIONS)) u_dist_ram (
      .clock (clock),
      .we    (dist_we),
      .waddr (dist_waddr),
      .wdata (DIST_WIDTH'(req_load)),
      .raddr (dist_raddr),
      .rdata (dist_rd)
   );

   cstc_ram #(.WIDTH(COST_W), .DEPTH(NSUBSETS * NCUST)) u_path_ram (
      .clock (clock),
      .we    (path_we),
      .waddr (path_waddr),
      .wdata (path_wdata),
      .raddr (path_raddr),
      .rdata (path_rd)
   );

   // {feasible, tour cost} per subset
   cstc_ram #(.WIDTH(COST_W + 1), .DEPTH(NSUBSETS)) u_tour_ram (
      .clock (clock),
      .we    (tour_we),
      .waddr (tour_waddr),
      .wdata (tour_wdata),
      .raddr (tour_raddr),
      .rdata (tour_rd)
   );

   // customers in use
   logic [4:0]       locs;
   logic [NCUST-1:0] used;
   always_comb begin
      locs = ({1'b0, numloc_ff} > 5'(MAX_LOCATIONS)) ? 5'(MAX_LOCATIONS) : {1'b0, numloc_ff};
      for (int k = 0; k < NCUST; k++) begin
         used[k] = (5'(k + 1) < locs);
      end
   end

   // shared add/saturate/compare unit
   logic [SUM_W-1:0]  sum;
   logic [COST_W-1:0] cand;
   assign sum  = SUM_W'(path_rd) + SUM_W'(dist_rd);
   assign cand = (sum > SUM_W'(cstc_pkg::COST_MAX)) ? cstc_pkg::COST_MAX : sum[COST_W-1:0];

   logic [NCUST-1:0] prev;
   logic             single;
   logic             in_xfer;
   assign prev    = m_ff & ~(NCUST'(1) << j_ff);
   assign single  = ((m_ff & (m_ff - NCUST'(1))) == '0);
   assign in_xfer = req_tvalid && req_tready;

   always_comb begin
      state_in       = state_ff;
      m_in           = m_ff;
      j_in           = j_ff;
      v_in           = v_ff;
      total_in       = total_ff;
      best_in        = best_ff;
      have_in        = have_ff;
      set_in         = set_ff;
      tgt_in         = tgt_ff;
      fin_in         = fin_ff;
      table_valid_in = table_valid_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_cost_in    = rsp_cost_ff;
      rsp_feas_in    = rsp_feas_ff;
      req_tready     = 1'b0;
      dist_we        = 1'b0;
      dist_waddr     = DAW'(req_row) * DAW'(MAX_LOCATIONS) + DAW'(req_col);
      dist_raddr     = DAW'(LIW'(v_ff) + LIW'(1)) * DAW'(MAX_LOCATIONS) + DAW'(tgt_ff);
      path_we        = 1'b0;
      path_waddr     = PAW'(m_ff) * PAW'(NCUST) + PAW'(j_ff);
      path_wdata     = best_ff;
      path_raddr     = PAW'(set_ff) * PAW'(NCUST) + PAW'(v_ff);
      tour_we        = 1'b0;
      tour_waddr     = m_ff;
      tour_wdata     = '0;
      tour_raddr     = NCUST'(req_mask);

      unique case (state_ff)
         cstc_pkg::ST_IDLE: begin
            req_tready = !rsp_valid_ff || rsp_tready;
            if (req_tvalid && req_tready) begin
               unique case (req_op)
                  cstc_pkg::OP_WRITE_DIST: begin
                     dist_we = ({1'b0, req_row} < 5'(MAX_LOCATIONS)) &&
                               ({1'b0, req_col} < 5'(MAX_LOCATIONS));
                  end
                  cstc_pkg::OP_WRITE_DEMAND: begin
                  end
                  cstc_pkg::OP_RUN: begin
                     m_in     = '0;
                     state_in = cstc_pkg::ST_CHK;
                  end
                  cstc_pkg::OP_QUERY: begin
                     state_in = cstc_pkg::ST_QWAIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         cstc_pkg::ST_QWAIT: begin
            rsp_valid_in = 1'b1;
            rsp_feas_in  = table_valid_ff && tour_rd[COST_W];
            rsp_cost_in  = (table_valid_ff && tour_rd[COST_W]) ? tour_rd[COST_W-1:0] : '0;
            state_in     = cstc_pkg::ST_IDLE;
         end
         cstc_pkg::ST_CHK: begin
            if (m_ff == '0 || (m_ff & ~used) != '0) begin
               tour_we  = 1'b1;
               state_in = cstc_pkg::ST_NEXT;
            end else begin
               j_in     = '0;
               total_in = '0;
               state_in = cstc_pkg::ST_DEM;
            end
         end
         cstc_pkg::ST_DEM: begin
            if (m_ff[j_ff]) begin
               total_in = total_ff + TOT_W'(demand_ff[LIW'(j_ff) + LIW'(1)]);
            end
            if (j_ff == JIW'(NCUST - 1)) begin
               state_in = cstc_pkg::ST_FEAS;
            end else begin
               j_in = j_ff + JIW'(1);
            end
         end
         cstc_pkg::ST_FEAS: begin
            if (single || total_ff <= TOT_W'(cap_ff)) begin
               j_in     = '0;
               state_in = cstc_pkg::ST_JSEL;
            end else begin
               tour_we  = 1'b1;
               state_in = cstc_pkg::ST_NEXT;
            end
         end
         cstc_pkg::ST_JSEL: begin
            // path ending at customer j
            priority if (!m_ff[j_ff]) begin
               if (j_ff == JIW'(NCUST - 1)) begin
                  state_in = cstc_pkg::ST_FIN;
               end else begin
                  j_in = j_ff + JIW'(1);
               end
            end else if (prev == '0) begin
               dist_raddr = DAW'(LIW'(j_ff) + LIW'(1));
               state_in   = cstc_pkg::ST_ROOT;
            end else begin
               set_in   = prev;
               tgt_in   = LIW'(j_ff) + LIW'(1);
               fin_in   = 1'b0;
               v_in     = '0;
               have_in  = 1'b0;
               state_in = cstc_pkg::ST_RD;
            end
         end
         cstc_pkg::ST_ROOT: begin
            best_in  = COST_W'(dist_rd);
            state_in = cstc_pkg::ST_WPATH;
         end
         cstc_pkg::ST_RD: begin
            state_in = cstc_pkg::ST_ACC;
         end
         cstc_pkg::ST_ACC: begin
            if (set_ff[v_ff] && (!have_ff || cand < best_ff)) begin
               best_in = cand;
               have_in = 1'b1;
            end
            if (v_ff == JIW'(NCUST - 1)) begin
               state_in = fin_ff ? cstc_pkg::ST_WTOUR : cstc_pkg::ST_WPATH;
            end else begin
               v_in     = v_ff + JIW'(1);
               state_in = cstc_pkg::ST_RD;
            end
         end
         cstc_pkg::ST_WPATH: begin
            path_we = 1'b1;
            if (j_ff == JIW'(NCUST - 1)) begin
               state_in = cstc_pkg::ST_FIN;
            end else begin
               j_in     = j_ff + JIW'(1);
               state_in = cstc_pkg::ST_JSEL;
            end
         end
         cstc_pkg::ST_FIN: begin
            // closing leg back to the depot
            set_in   = m_ff;
            tgt_in   = '0;
            fin_in   = 1'b1;
            v_in     = '0;
            have_in  = 1'b0;
            state_in = cstc_pkg::ST_RD;
         end
         cstc_pkg::ST_WTOUR: begin
            tour_we    = 1'b1;
            tour_wdata = {1'b1, best_ff};
            state_in   = cstc_pkg::ST_NEXT;
         end
         cstc_pkg::ST_NEXT: begin
            if (m_ff == '1) begin
               table_valid_in = 1'b1;
               state_in       = cstc_pkg::ST_IDLE;
            end else begin
               m_in     = m_ff + NCUST'(1);
               state_in = cstc_pkg::ST_CHK;
            end
         end
         default: begin
            state_in = cstc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= cstc_pkg::ST_IDLE;
         table_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         numloc_ff      <= cstc_pkg::NUMLOC_RESET;
         cap_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         table_valid_ff <= table_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               cstc_pkg::CSR_NUM_LOCATIONS: numloc_ff <= csr_wdata[cstc_pkg::NUMLOC_W-1:0];
               cstc_pkg::CSR_VEHICLE_CAPACITY: cap_ff <= csr_wdata[cstc_pkg::CAP_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      m_ff        <= m_in;
      j_ff        <= j_in;
      v_ff        <= v_in;
      total_ff    <= total_in;
      best_ff     <= best_in;
      have_ff     <= have_in;
      set_ff      <= set_in;
      tgt_ff      <= tgt_in;
      fin_ff      <= fin_in;
      rsp_cost_ff <= rsp_cost_in;
      rsp_feas_ff <= rsp_feas_in;
      if (in_xfer && req_op == cstc_pkg::OP_WRITE_DEMAND &&
          {1'b0, req_row} < 5'(MAX_LOCATIONS)) begin
         demand_ff[req_row[LIW-1:0]] <= req_load;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(cstc_pkg::RSP_W - COST_W - 1)'(0), rsp_feas_ff, rsp_cost_ff};

   // a query answers after the registered tour RAM read and the output register
   assert property (@(posedge clock) disable iff (reset)
      (in_xfer && req_op == cstc_pkg::OP_QUERY) |=> ##1 rsp_tvalid)
      else $error("query result missing");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[COST_W]) |-> table_valid_ff)
      else $error("feasible reported before any run");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[COST_W]) |-> (rsp_tdata[COST_W-1:0] == '0))
      else $error("infeasible subset with nonzero cost");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == cstc_pkg::ST_WTOUR) |-> have_ff)
      else $error("tour written without any member");

endmodule
`default_nettype wire
